>>> sv/cbd_pkg.sv
// Shared types, codes and opcode decode for the command byte deframer.
package cbd_pkg;

    // Fixed field widths
    localparam int RX_W    = 8;
    localparam int CODE_W  = 5;
    localparam int INDEX_W = 10;
    localparam int EVENT_W = 2;

    // Highest defined opcode and default parameter bound
    localparam logic [RX_W-1:0] OPCODE_MAX = 8'd20;
    localparam int MAX_PARAMS_DEF = 1024;

    // Opcode of the counted command whose count byte is multiplied by three
    localparam logic [CODE_W-1:0] OP_COUNT_X3 = 5'd1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_READ  = 2'd2
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_PARAM = 2'd1,
        EV_DONE  = 2'd2,
        EV_BUSY  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        OK_IMM,
        OK_FIXED,
        OK_COUNTED,
        OK_BUSY
    } t_op_kind;

    typedef struct packed {
        logic [RX_W-1:0] rx_byte;
        logic            mover_busy;
    } t_in_item;

    // Classify a defined opcode
    function automatic t_op_kind op_kind(input logic [CODE_W-1:0] op);
        t_op_kind k;
        unique case (op)
            5'd1, 5'd2:                               k = OK_COUNTED;
            5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
            5'd10, 5'd11, 5'd12, 5'd17:               k = OK_FIXED;
            5'd20:                                    k = OK_BUSY;
            default:                                  k = OK_IMM;
        endcase
        return k;
    endfunction

    // Parameter byte count of a fixed-run opcode
    function automatic logic [2:0] op_fixed_len(input logic [CODE_W-1:0] op);
        logic [2:0] n;
        unique case (op)
            5'd3:                             n = 3'd3;
            5'd4:                             n = 3'd4;
            5'd5, 5'd7, 5'd10, 5'd12:         n = 3'd2;
            5'd6, 5'd11, 5'd17:               n = 3'd1;
            default:                          n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> sv/cbd_in_reg.sv
// Input register stage of the command byte deframer.
module cbd_in_reg
    import cbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Take a new item whenever the stage is empty or drains this cycle
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> sv/cbd_core.sv
// Framing state machine and result register of the command byte deframer.
module cbd_core
    import cbd_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_item           i_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [EVENT_W-1:0] o_event_res,
    output logic [CODE_W-1:0]  o_command_code,
    output logic [INDEX_W-1:0] o_param_index,
    output logic [RX_W-1:0]    o_param_value,
    output logic               o_command_done,
    output logic               o_reply_byte
);

    localparam int LEFT_W = $clog2(MAX_PARAMS);
    localparam logic [INDEX_W-1:0] SAT_TOTAL = INDEX_W'(MAX_PARAMS - 1);

    t_phase              r_phase, n_phase;
    logic [CODE_W-1:0]   r_pending, n_pending;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [INDEX_W-1:0]  r_index, n_index;

    logic                r_out_valid;
    t_event              r_event, n_event;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [INDEX_W-1:0]  r_pidx, n_pidx;
    logic [RX_W-1:0]     r_pval, n_pval;
    logic                r_done, n_done;
    logic                r_reply, n_reply;

    logic                take;
    logic [RX_W-1:0]     b;
    logic [CODE_W-1:0]   op;
    logic                op_known;
    t_op_kind            kind;
    logic [INDEX_W-1:0]  raw_total, total;
    logic                read_last;

    assign o_ready = !r_out_valid || i_out_ready;
    assign take    = i_valid && o_ready;

    // Decode the byte as opcode and as count
    assign b        = i_item.rx_byte;
    assign op       = b[CODE_W-1:0];
    assign op_known = (b <= OPCODE_MAX);
    assign kind     = op_kind(op);

    always_comb begin
        if (r_pending == OP_COUNT_X3) begin
            raw_total = {2'b00, b} + {1'b0, b, 1'b0};
        end else begin
            raw_total = {b, 2'b00};
        end
        total = (raw_total > SAT_TOTAL) ? SAT_TOTAL : raw_total;
    end

    // Last parameter when the run empties (an empty run also ends)
    assign read_last = (r_left <= LEFT_W'(1));

    // Next framing state
    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_left    = r_left;
        n_index   = r_index;
        if (take) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_index = '0;
                    if (op_known) begin
                        if (kind == OK_COUNTED) begin
                            n_pending = op;
                            n_phase   = PH_COUNT;
                        end else if (kind == OK_FIXED) begin
                            n_pending = op;
                            n_left    = LEFT_W'(op_fixed_len(op));
                            n_phase   = PH_READ;
                        end
                    end
                end
                PH_COUNT: begin
                    n_left  = total[LEFT_W-1:0];
                    n_index = INDEX_W'(1);
                    n_phase = (total == '0) ? PH_IDLE : PH_READ;
                end
                PH_READ: begin
                    n_index = r_index + INDEX_W'(1);
                    if (r_left != '0) begin
                        n_left = r_left - LEFT_W'(1);
                    end
                    if (read_last) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Result for the current item
    always_comb begin
        n_event = EV_NONE;
        n_code  = '0;
        n_pidx  = '0;
        n_pval  = '0;
        n_done  = 1'b0;
        n_reply = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (op_known && kind == OK_IMM) begin
                    n_event = EV_DONE;
                    n_code  = op;
                    n_done  = 1'b1;
                end else if (op_known && kind == OK_BUSY) begin
                    n_event = EV_BUSY;
                    n_code  = op;
                    n_reply = i_item.mover_busy;
                end
            end
            PH_COUNT: begin
                n_event = EV_PARAM;
                n_code  = r_pending;
                n_pval  = b;
                n_done  = (total == '0);
            end
            PH_READ: begin
                n_event = EV_PARAM;
                n_code  = r_pending;
                n_pidx  = r_index;
                n_pval  = b;
                n_done  = read_last;
            end
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= '0;
            r_left    <= '0;
            r_index   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_left    <= n_left;
            r_index   <= n_index;
        end
    end

    // Result register: load on take, drop valid once delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_event <= n_event;
            r_code  <= n_code;
            r_pidx  <= n_pidx;
            r_pval  <= n_pval;
            r_done  <= n_done;
            r_reply <= n_reply;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_event;
    assign o_command_code = r_code;
    assign o_param_index  = r_pidx;
    assign o_param_value  = r_pval;
    assign o_command_done = r_done;
    assign o_reply_byte   = r_reply;

endmodule

>>> sv/command_byte_deframer.sv
// Command byte deframer: frames received bytes into commands, one result per byte.
// Each accepted byte yields exactly one result item: nothing, a count or
// parameter byte with its index and a done mark, a command-complete, or a
// busy reply. The block takes one byte every cycle when the output side is
// not stalled; a byte passes an input register and then the framing logic
// into a result register, which drives the outputs.
// Both sides use valid/ready; a stall on the output holds the pipeline.
// MAX_PARAMS bounds the parameter run of a counted command (count*3 or
// count*4, saturated at MAX_PARAMS-1).
module command_byte_deframer
    import cbd_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [RX_W-1:0]    i_rx_byte,
    input  logic               i_mover_busy,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [EVENT_W-1:0] o_event_res,
    output logic [CODE_W-1:0]  o_command_code,
    output logic [INDEX_W-1:0] o_param_index,
    output logic [RX_W-1:0]    o_param_value,
    output logic               o_command_done,
    output logic               o_reply_byte
);

    t_in_item in_item, s1_item;
    logic     s1_valid, s1_ready;

    assign in_item.rx_byte    = i_rx_byte;
    assign in_item.mover_busy = i_mover_busy;

    // Input register
    cbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_item  (s1_item)
    );

    // Framing logic and result register
    cbd_core #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s1_valid),
        .o_ready        (s1_ready),
        .i_item         (s1_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_command_code (o_command_code),
        .o_param_index  (o_param_index),
        .o_param_value  (o_param_value),
        .o_command_done (o_command_done),
        .o_reply_byte   (o_reply_byte)
    );

endmodule

>>> test/cbd_tb_pkg.sv
// Opcode classes and argument run lengths shared by the deframer testbench files.
package cbd_tb_pkg;
    import cbd_pkg::*;

    typedef enum logic [2:0] {
        CMD_IMMEDIATE,
        CMD_FIXED,
        CMD_COUNTED,
        CMD_QUERY,
        CMD_UNKNOWN
    } t_cmd_class;

    localparam logic [RX_W-1:0] OP_COUNT_X4   = 8'd2;
    localparam logic [RX_W-1:0] OP_BUSY_QUERY = 8'd20;
    localparam int              COUNT_X3_MULT = 3;
    localparam int              COUNT_X4_MULT = 4;

    // Number of argument bytes behind a fixed-run opcode, zero for any other byte
    function automatic int arg_bytes(input logic [RX_W-1:0] op);
        int n;
        case (op)
            8'd3:                        n = 3;
            8'd4:                        n = 4;
            8'd5, 8'd7, 8'd10, 8'd12:    n = 2;
            8'd6, 8'd11, 8'd17:          n = 1;
            default:                     n = 0;
        endcase
        return n;
    endfunction

    // Sort a byte seen in the idle phase into its command class
    function automatic t_cmd_class cmd_class(input logic [RX_W-1:0] op);
        t_cmd_class c;
        if (op > OPCODE_MAX) begin
            c = CMD_UNKNOWN;
        end else if (op == OP_BUSY_QUERY) begin
            c = CMD_QUERY;
        end else if (op == RX_W'(OP_COUNT_X3) || op == OP_COUNT_X4) begin
            c = CMD_COUNTED;
        end else if (arg_bytes(op) != 0) begin
            c = CMD_FIXED;
        end else begin
            c = CMD_IMMEDIATE;
        end
        return c;
    endfunction

endpackage

>>> test/cbd_frame_checker.sv
// Result checker for the command byte deframer: predicts each byte's result and compares.
module cbd_frame_checker
    import cbd_pkg::*;
    import cbd_tb_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [RX_W-1:0]    i_rx_byte,
    input  logic               i_mover_busy,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [EVENT_W-1:0] i_event_res,
    input  logic [CODE_W-1:0]  i_command_code,
    input  logic [INDEX_W-1:0] i_param_index,
    input  logic [RX_W-1:0]    i_param_value,
    input  logic               i_command_done,
    input  logic               i_reply_byte,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        t_event             ev;
        logic [CODE_W-1:0]  code;
        logic [INDEX_W-1:0] idx;
        logic [RX_W-1:0]    value;
        logic               done;
        logic               reply;
    } t_frame_result;

    // Framing state of the predicted block
    t_phase             phase;
    logic [CODE_W-1:0]  framed_op;
    logic [INDEX_W-1:0] args_left;
    logic [INDEX_W-1:0] arg_pos;

    t_frame_result      results_due[$];
    int                 results_seen;

    // Advance the framing state by one byte and return the result it causes
    function automatic t_frame_result frame_byte(input logic [RX_W-1:0] b, input logic busy);
        t_frame_result      r;
        int                 total;
        logic [INDEX_W-1:0] pos;
        r = '0;
        case (phase)
            PH_IDLE: begin
                arg_pos = '0;
                case (cmd_class(b))
                    CMD_IMMEDIATE: begin
                        r.ev   = EV_DONE;
                        r.code = b[CODE_W-1:0];
                        r.done = 1'b1;
                    end
                    CMD_QUERY: begin
                        r.ev    = EV_BUSY;
                        r.code  = b[CODE_W-1:0];
                        r.reply = busy;
                    end
                    CMD_COUNTED: begin
                        framed_op = b[CODE_W-1:0];
                        phase     = PH_COUNT;
                    end
                    CMD_FIXED: begin
                        framed_op = b[CODE_W-1:0];
                        args_left = INDEX_W'(arg_bytes(b));
                        phase     = PH_READ;
                    end
                    default: ;
                endcase
            end
            PH_COUNT: begin
                // Widen the run before saturating so large counts never wrap
                total = int'(b) * ((framed_op == OP_COUNT_X3) ? COUNT_X3_MULT : COUNT_X4_MULT);
                if (total > MAX_PARAMS - 1) begin
                    total = MAX_PARAMS - 1;
                end
                args_left = INDEX_W'(total);
                arg_pos   = INDEX_W'(1);
                r.ev      = EV_PARAM;
                r.code    = framed_op;
                r.value   = b;
                r.done    = (total == 0);
                phase     = (total == 0) ? PH_IDLE : PH_READ;
            end
            PH_READ: begin
                pos     = arg_pos;
                arg_pos = arg_pos + INDEX_W'(1);
                // An empty run treats the byte as its last
                if (args_left != '0) begin
                    args_left = args_left - INDEX_W'(1);
                end
                r.ev    = EV_PARAM;
                r.code  = framed_op;
                r.idx   = pos;
                r.value = b;
                r.done  = (args_left == '0);
                if (args_left == '0) begin
                    phase = PH_IDLE;
                end
            end
            default: begin
                phase = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP) begin
            $display("[%0t] result %0d mismatch: %s", $time, results_seen, what);
        end
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        end
    endtask

    // Predict on each accepted byte, compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            phase        = PH_IDLE;
            framed_op    = '0;
            args_left    = '0;
            arg_pos      = '0;
            results_seen = 0;
            o_fail_count = 0;
            results_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(frame_byte(i_rx_byte, i_mover_busy));
            end
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = results_due.pop_front();
                    compare_field("event", int'(i_event_res), int'(want.ev));
                    compare_field("command_code", int'(i_command_code), int'(want.code));
                    compare_field("param_index", int'(i_param_index), int'(want.idx));
                    compare_field("param_value", int'(i_param_value), int'(want.value));
                    compare_field("command_done", int'(i_command_done), int'(want.done));
                    compare_field("reply_byte", int'(i_reply_byte), int'(want.reply));
                end
            end
        end
        o_pending <= results_due.size();
    end

endmodule

>>> test/tb_command_byte_deframer.sv
// Testbench top for the command byte deframer: byte stimulus, output stalls, verdict.
module tb_command_byte_deframer;
    import cbd_pkg::*;
    import cbd_tb_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int LONG_COUNT   = 96;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RESET_CYCLES = 12;
    localparam int BYTE_MAX     = (1 << RX_W) - 1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [RX_W-1:0]    i_rx_byte;
    logic               i_mover_busy;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [EVENT_W-1:0] o_event_res;
    logic [CODE_W-1:0]  o_command_code;
    logic [INDEX_W-1:0] o_param_index;
    logic [RX_W-1:0]    o_param_value;
    logic               o_command_done;
    logic               o_reply_byte;

    int       fail_count;
    int       results_pending;
    int       quiet_cycles;
    int       items_sent;
    bit       calm;
    bit       hold_asked;
    bit       hold_served;
    t_in_item byte_stream[$];

    command_byte_deframer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_mover_busy   (i_mover_busy),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_command_code (o_command_code),
        .o_param_index  (o_param_index),
        .o_param_value  (o_param_value),
        .o_command_done (o_command_done),
        .o_reply_byte   (o_reply_byte)
    );

    cbd_frame_checker frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_mover_busy   (i_mover_busy),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_event_res    (o_event_res),
        .i_command_code (o_command_code),
        .i_param_index  (o_param_index),
        .i_param_value  (o_param_value),
        .i_command_done (o_command_done),
        .i_reply_byte   (o_reply_byte),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic add_byte(input logic [RX_W-1:0] b, input logic busy);
        t_in_item item;
        item.rx_byte    = b;
        item.mover_busy = busy;
        byte_stream.push_back(item);
    endtask

    // Queue one well-formed command: opcode, count byte where it takes one, then its arguments
    task automatic add_command(input logic [RX_W-1:0] op, input int count);
        int n;
        n = 0;
        add_byte(op, 1'($urandom_range(0, 1)));
        case (cmd_class(op))
            CMD_FIXED: begin
                n = arg_bytes(op);
            end
            CMD_COUNTED: begin
                add_byte(RX_W'(count), 1'($urandom_range(0, 1)));
                n = count * ((op == RX_W'(OP_COUNT_X3)) ? COUNT_X3_MULT : COUNT_X4_MULT);
            end
            default: ;
        endcase
        repeat (n) begin
            add_byte(RX_W'($urandom_range(0, BYTE_MAX)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Build the byte stream, run reset, then offer every byte with random gaps
    initial begin
        logic [RX_W-1:0] op;
        int              count;
        int              sel;
        int              target;
        int              quiet_items;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_rx_byte    = '0;
        i_mover_busy = 1'b0;
        items_sent   = 0;
        calm         = 1'b0;
        hold_asked   = 1'b0;
        quiet_items  = 0;

        // Directed: every immediate opcode, longest fixed run with extreme bytes
        for (int k = 0; k <= int'(OPCODE_MAX); k++) begin
            op = RX_W'(k);
            if (cmd_class(op) == CMD_IMMEDIATE) begin
                add_byte(op, 1'($urandom_range(0, 1)));
            end else if (arg_bytes(op) == 4) begin
                add_byte(op, 1'b0);
                repeat (2) begin
                    add_byte('1, 1'b1);
                    add_byte('0, 1'b0);
                end
            end
        end
        // Busy query both ways, unknown opcodes at both ends of their range
        add_byte(OP_BUSY_QUERY, 1'b0);
        add_byte(OP_BUSY_QUERY, 1'b1);
        add_byte(OPCODE_MAX + RX_W'(1), 1'b0);
        add_byte('1, 1'b1);
        // Zero count closes a counted command on the count byte
        add_byte(RX_W'(OP_COUNT_X3), 1'b0);
        add_byte('0, 1'b1);
        add_byte(OP_COUNT_X4, 1'b1);
        add_byte('0, 1'b0);

        // One long counted run past 8 bits, then mostly short commands with some noise
        add_command(OP_COUNT_X4, LONG_COUNT);
        target = byte_stream.size() + RANDOM_ITEMS;
        while (byte_stream.size() < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                add_byte(RX_W'($urandom_range(int'(OPCODE_MAX) + 1, BYTE_MAX)),
                         1'($urandom_range(0, 1)));
            end else if (sel < 9) begin
                // Bare opcode: its arguments never come and later bytes fill in
                add_byte(RX_W'($urandom_range(0, int'(OPCODE_MAX))), 1'($urandom_range(0, 1)));
            end else begin
                op  = RX_W'($urandom_range(0, int'(OPCODE_MAX)));
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    count = 0;
                end else if (sel < 16) begin
                    count = $urandom_range(1, 4);
                end else if (sel < 19) begin
                    count = $urandom_range(5, 20);
                end else begin
                    count = $urandom_range(21, 64);
                end
                add_command(op, count);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (byte_stream[k]) begin
            // Alternate stretches without gaps and stretches with gap bursts
            if (quiet_items > 0) begin
                quiet_items--;
            end else if ($urandom_range(0, 29) == 0) begin
                quiet_items = $urandom_range(20, 80);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_rx_byte    <= byte_stream[k].rx_byte;
            i_mover_busy <= byte_stream[k].mover_busy;
            do @(posedge i_clk); while (!o_in_ready);
            items_sent++;
            if (items_sent == byte_stream.size() / 3) begin
                hold_asked = 1'b1;
            end
            if (items_sent == byte_stream.size() - TAIL_ITEMS) begin
                calm = 1'b1;
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every expected result, then watch for stray results
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Output side: random stall bursts, one long hold so the block backs up
    initial begin
        i_out_ready = 1'b0;
        hold_served = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_asked && !hold_served) begin
                hold_served = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run when neither channel moves an item for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> sim.f
sv/cbd_pkg.sv
sv/cbd_in_reg.sv
sv/cbd_core.sv
sv/command_byte_deframer.sv
test/cbd_tb_pkg.sv
test/cbd_frame_checker.sv
test/tb_command_byte_deframer.sv
